// ----- design/gvp_pkg.sv -----
// Shared types, register codes and sequencer step table for the gait velocity and phase block.
`timescale 1ns / 1ps
package gvp_pkg;

  localparam int VEL_WIDTH_DEF   = 16;
  localparam int PHASE_WIDTH_DEF = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_BIAS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LIMITS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECEL_RATIO      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_RATE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_TOLERANCES  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_SPEED_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_LEG_LEADS   = 3'd6;

  typedef struct packed {
    logic [47:0] velocity_bias;
    logic [63:0] accel_limits;
    logic [15:0] decel_ratio;
    logic [15:0] phase_rate;
    logic [31:0] stop_tolerances;
    logic [14:0] stop_speed_limit;
    logic        left_leg_leads;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    velocity_bias:    48'd0,
    accel_limits:     64'd0,
    decel_ratio:      16'd4096,
    phase_rate:       16'd32768,
    stop_tolerances:  32'd0,
    stop_speed_limit: 15'd0,
    left_leg_leads:   1'b1
  };

  // multiplier operand selects
  localparam int SEL_W = 4;
  localparam logic [SEL_W-1:0] MS_NONE = 4'd0;
  localparam logic [SEL_W-1:0] MS_TA0  = 4'd1;  // tick * accel, forward/backward
  localparam logic [SEL_W-1:0] MS_TA1  = 4'd2;  // tick * accel, sideways
  localparam logic [SEL_W-1:0] MS_TA2  = 4'd3;  // tick * accel, rotational
  localparam logic [SEL_W-1:0] MS_PD   = 4'd4;  // product * decel ratio
  localparam logic [SEL_W-1:0] MS_SQ0  = 4'd5;
  localparam logic [SEL_W-1:0] MS_SQ1  = 4'd6;
  localparam logic [SEL_W-1:0] MS_SQ2  = 4'd7;
  localparam logic [SEL_W-1:0] MS_TP   = 4'd8;  // tick * phase rate
  localparam logic [SEL_W-1:0] MS_NP   = 4'd9;  // nominal tick * phase rate
  localparam logic [SEL_W-1:0] MS_NL   = 4'd10; // nominal increment * lower tol
  localparam logic [SEL_W-1:0] MS_NU   = 4'd11; // nominal increment * upper tol
  localparam logic [SEL_W-1:0] MS_LL   = 4'd12; // speed limit squared

  // product capture targets
  localparam logic [SEL_W-1:0] CAP_NONE  = 4'd0;
  localparam logic [SEL_W-1:0] CAP_ALIM0 = 4'd1;
  localparam logic [SEL_W-1:0] CAP_ALIM1 = 4'd2;
  localparam logic [SEL_W-1:0] CAP_ALIM2 = 4'd3;
  localparam logic [SEL_W-1:0] CAP_DLIM0 = 4'd4;
  localparam logic [SEL_W-1:0] CAP_DLIM1 = 4'd5;
  localparam logic [SEL_W-1:0] CAP_DLIM2 = 4'd6;
  localparam logic [SEL_W-1:0] CAP_SQ    = 4'd7;
  localparam logic [SEL_W-1:0] CAP_INC   = 4'd8;
  localparam logic [SEL_W-1:0] CAP_NOM   = 4'd9;
  localparam logic [SEL_W-1:0] CAP_LB    = 4'd10;
  localparam logic [SEL_W-1:0] CAP_UB    = 4'd11;
  localparam logic [SEL_W-1:0] CAP_LIM2  = 4'd12;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] LAST_STEP = 4'd14;

  typedef struct packed {
    logic             load;
    logic             update;
    logic [SEL_W-1:0] mul_sel;
    logic [SEL_W-1:0] cap_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic walking;
  } dp_stat_t;

  // Each step but the last starts one product; each step but the first captures the one started the step before.
  function automatic dp_cmd_t step_cmd(input logic [STEP_W-1:0] s);
    dp_cmd_t c;
    c = '0;
    case (s)
      4'd0:    begin c.mul_sel = MS_TA0;  c.cap_sel = CAP_NONE;  end
      4'd1:    begin c.mul_sel = MS_PD;   c.cap_sel = CAP_ALIM0; end
      4'd2:    begin c.mul_sel = MS_TA1;  c.cap_sel = CAP_DLIM0; end
      4'd3:    begin c.mul_sel = MS_PD;   c.cap_sel = CAP_ALIM1; end
      4'd4:    begin c.mul_sel = MS_TA2;  c.cap_sel = CAP_DLIM1; end
      4'd5:    begin c.mul_sel = MS_PD;   c.cap_sel = CAP_ALIM2; end
      4'd6:    begin c.mul_sel = MS_SQ0;  c.cap_sel = CAP_DLIM2; end
      4'd7:    begin c.mul_sel = MS_SQ1;  c.cap_sel = CAP_SQ;    end
      4'd8:    begin c.mul_sel = MS_SQ2;  c.cap_sel = CAP_SQ;    end
      4'd9:    begin c.mul_sel = MS_TP;   c.cap_sel = CAP_SQ;    end
      4'd10:   begin c.mul_sel = MS_NP;   c.cap_sel = CAP_INC;   end
      4'd11:   begin c.mul_sel = MS_NL;   c.cap_sel = CAP_NOM;   end
      4'd12:   begin c.mul_sel = MS_NU;   c.cap_sel = CAP_LB;    end
      4'd13:   begin c.mul_sel = MS_LL;   c.cap_sel = CAP_UB;    end
      4'd14:   begin c.mul_sel = MS_NONE; c.cap_sel = CAP_LIM2;  end
      default: begin c.mul_sel = MS_NONE; c.cap_sel = CAP_NONE;  end
    endcase
    return c;
  endfunction

endpackage

// ----- design/gvp_ifs.sv -----
// Channel interfaces: input word, result word and configuration write.
`timescale 1ns / 1ps
interface gvp_in_if;
  logic               valid;
  logic               ready;
  logic               walk_request;
  logic signed [15:0] cmd_vel_x;
  logic signed [15:0] cmd_vel_y;
  logic signed [15:0] cmd_vel_z;
  logic [15:0]        tick_time;
  logic [15:0]        nominal_tick_time;

  modport source (output valid, walk_request, cmd_vel_x, cmd_vel_y, cmd_vel_z,
                  tick_time, nominal_tick_time, input ready);
  modport sink (input valid, walk_request, cmd_vel_x, cmd_vel_y, cmd_vel_z,
                tick_time, nominal_tick_time, output ready);
endinterface

interface gvp_out_if #(
  parameter int VEL_WIDTH   = gvp_pkg::VEL_WIDTH_DEF,
  parameter int PHASE_WIDTH = gvp_pkg::PHASE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          is_walking;
  logic signed [VEL_WIDTH-1:0]   vel_x;
  logic signed [VEL_WIDTH-1:0]   vel_y;
  logic signed [VEL_WIDTH-1:0]   vel_z;
  logic signed [PHASE_WIDTH-1:0] phase;
  logic                          leading_left;

  modport source (output valid, is_walking, vel_x, vel_y, vel_z, phase, leading_left,
                  input ready);
  modport sink (input valid, is_walking, vel_x, vel_y, vel_z, phase, leading_left,
                output ready);
endinterface

interface gvp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gvp_pkg::CFG_IDX_W-1:0]   reg_index;
  logic [gvp_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, reg_index, data, input ready);
  modport sink (input valid, reg_index, data, output ready);
endinterface

// ----- design/gvp_regs.sv -----
// Configuration register file.
`timescale 1ns / 1ps
module gvp_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [gvp_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [gvp_pkg::CFG_DATA_W-1:0] wr_data,
  output gvp_pkg::cfg_t                  cfg
);
  import gvp_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_VELOCITY_BIAS:    cfg_r.velocity_bias    <= wr_data[47:0];
        REG_ACCEL_LIMITS:     cfg_r.accel_limits     <= wr_data;
        REG_DECEL_RATIO:      cfg_r.decel_ratio      <= wr_data[15:0];
        REG_PHASE_RATE:       cfg_r.phase_rate       <= wr_data[15:0];
        REG_STOP_TOLERANCES:  cfg_r.stop_tolerances  <= wr_data[31:0];
        REG_STOP_SPEED_LIMIT: cfg_r.stop_speed_limit <= wr_data[14:0];
        REG_LEFT_LEG_LEADS:   cfg_r.left_leg_leads   <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- design/gvp_ctrl.sv -----
// Sequencer: handshakes and the step schedule for the shared multiplier.
`timescale 1ns / 1ps
module gvp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  gvp_pkg::dp_stat_t stat,
  output gvp_pkg::dp_cmd_t  cmd
);
  import gvp_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              accept;
  logic              out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid & in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = stat.walking ? ST_RUN : ST_UPD;
        end
      end
      ST_RUN: begin
        cmd = step_cmd(step_r);
        if (step_r == LAST_STEP) begin
          state_nxt = ST_UPD;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_UPD: begin
        if (out_free) begin
          cmd.update = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.update) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("input still ready after a word was taken");
  a_halted_goes_update: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !stat.walking |=> state_r == ST_UPD)
    else $error("halted word did not go straight to update");
  a_update_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> out_valid_r)
    else $error("update without a result word");
`endif

endmodule

// ----- design/gvp_dp.sv -----
// Datapath: shared multiplier, captured limits, slope limiter, phase and stop logic.
`timescale 1ns / 1ps
module gvp_dp #(
  parameter int VEL_WIDTH   = gvp_pkg::VEL_WIDTH_DEF,
  parameter int PHASE_WIDTH = gvp_pkg::PHASE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          walk_request,
  input  logic signed [15:0]            cmd_vel_x,
  input  logic signed [15:0]            cmd_vel_y,
  input  logic signed [15:0]            cmd_vel_z,
  input  logic [15:0]                   tick_time,
  input  logic [15:0]                   nominal_tick_time,
  input  gvp_pkg::cfg_t                 cfg,
  input  gvp_pkg::dp_cmd_t              cmd,
  output gvp_pkg::dp_stat_t             stat,
  output logic                          is_walking,
  output logic signed [VEL_WIDTH-1:0]   vel_x,
  output logic signed [VEL_WIDTH-1:0]   vel_y,
  output logic signed [VEL_WIDTH-1:0]   vel_z,
  output logic signed [PHASE_WIDTH-1:0] phase,
  output logic                          leading_left
);
  import gvp_pkg::*;

  localparam int VW  = VEL_WIDTH;
  localparam int PW  = PHASE_WIDTH;
  localparam int UW  = ((VW > 16) ? VW : 16) + 1;   // unbiased velocity
  localparam int DW  = ((VW > 17) ? VW : 17) + 1;   // target - velocity
  localparam int KW  = ((DW > 21) ? DW : 21) + 1;   // clamp window
  localparam int SW  = KW + 1;                      // velocity + step
  localparam int PKW = ((PW > 24) ? PW : 24) + 2;   // phase tolerance compare

  localparam logic signed [SW-1:0] VMAX_S =
    signed'({{(SW-VW+1){1'b0}}, {(VW-1){1'b1}}});
  localparam logic signed [SW-1:0] VMIN_S = -VMAX_S - 1;
  localparam logic signed [UW-1:0] VMAX_U =
    signed'({{(UW-VW+1){1'b0}}, {(VW-1){1'b1}}});
  localparam logic signed [UW-1:0] VMIN_U = -VMAX_U - 1;

  // latched input word
  logic               walk_r;
  logic signed [15:0] cmd_r [3];
  logic [15:0]        t_r, tn_r;

  // multiplier and captured products
  logic [31:0] mul_a;
  logic [15:0] mul_b;
  logic [47:0] prod;
  logic [47:0] p_r;
  logic [15:0] alim_r [3];
  logic [19:0] dlim_r [3];
  logic [31:0] sum_r;
  logic [15:0] inc_r;
  logic [31:0] nominc_r;
  logic [23:0] lb_r, ub_r;
  logic [29:0] lim2_r;

  // gait state
  logic                 walking_r, walking_nxt;
  logic signed [VW-1:0] vel_r [3];
  logic signed [VW-1:0] vel_nxt [3];
  logic signed [PW-1:0] phase_r, phase_nxt;
  logic                 left_r, left_nxt;

  // per-axis results
  logic signed [UW-1:0] unb [3];
  logic [UW-1:0]        mag [3];
  logic                 nonneg [3];
  logic signed [VW-1:0] vel_new [3];
  logic signed [VW-1:0] bias_sat [3];
  logic [15:0]          acc_sel [3];

  assign acc_sel[0] = nonneg[0] ? cfg.accel_limits[15:0] : cfg.accel_limits[31:16];
  assign acc_sel[1] = cfg.accel_limits[47:32];
  assign acc_sel[2] = cfg.accel_limits[63:48];

  genvar gi;
  for (gi = 0; gi < 3; gi++) begin : g_axis
    logic [15:0]          b;
    logic signed [16:0]   tgt;
    logic signed [DW-1:0] diff;
    logic signed [KW-1:0] diff_k, a_k, d_k, lo_k, hi_k, clp;
    logic signed [SW-1:0] vs;
    logic signed [UW-1:0] bx;

    assign b = cfg.velocity_bias[16*gi +: 16];
    assign unb[gi] = $signed({{(UW-VW){vel_r[gi][VW-1]}}, vel_r[gi]})
                   - $signed({{(UW-16){b[15]}}, b});
    assign nonneg[gi] = !unb[gi][UW-1];
    assign mag[gi] = unb[gi][UW-1] ? -unb[gi] : unb[gi];

    // step toward bias plus command, bias alone without a walk request
    assign tgt  = $signed({b[15], b})
                + (walk_r ? $signed({cmd_r[gi][15], cmd_r[gi]}) : 17'sd0);
    assign diff = $signed({{(DW-17){tgt[16]}}, tgt})
                - $signed({{(DW-VW){vel_r[gi][VW-1]}}, vel_r[gi]});
    assign diff_k = $signed({{(KW-DW){diff[DW-1]}}, diff});
    assign a_k  = $signed({{(KW-16){1'b0}}, alim_r[gi]});
    assign d_k  = $signed({{(KW-20){1'b0}}, dlim_r[gi]});
    assign lo_k = nonneg[gi] ? -d_k : -a_k;
    assign hi_k = nonneg[gi] ? a_k : d_k;
    assign clp  = (diff_k < lo_k) ? lo_k : ((diff_k > hi_k) ? hi_k : diff_k);
    assign vs   = $signed({{(SW-VW){vel_r[gi][VW-1]}}, vel_r[gi]})
                + $signed({clp[KW-1], clp});
    assign vel_new[gi] = (vs > VMAX_S) ? VMAX_S[VW-1:0] :
                         ((vs < VMIN_S) ? VMIN_S[VW-1:0] : vs[VW-1:0]);

    assign bx = $signed({{(UW-16){b[15]}}, b});
    assign bias_sat[gi] = (bx > VMAX_U) ? VMAX_U[VW-1:0] :
                          ((bx < VMIN_U) ? VMIN_U[VW-1:0] : bx[VW-1:0]);
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      MS_TA0:  begin mul_a = {16'd0, t_r};          mul_b = acc_sel[0]; end
      MS_TA1:  begin mul_a = {16'd0, t_r};          mul_b = acc_sel[1]; end
      MS_TA2:  begin mul_a = {16'd0, t_r};          mul_b = acc_sel[2]; end
      MS_PD:   begin mul_a = p_r[31:0];             mul_b = cfg.decel_ratio; end
      MS_SQ0:  begin mul_a = {17'd0, mag[0][14:0]}; mul_b = {1'b0, mag[0][14:0]}; end
      MS_SQ1:  begin mul_a = {17'd0, mag[1][14:0]}; mul_b = {1'b0, mag[1][14:0]}; end
      MS_SQ2:  begin mul_a = {17'd0, mag[2][14:0]}; mul_b = {1'b0, mag[2][14:0]}; end
      MS_TP:   begin mul_a = {16'd0, t_r};          mul_b = cfg.phase_rate; end
      MS_NP:   begin mul_a = {16'd0, tn_r};         mul_b = cfg.phase_rate; end
      MS_NL:   begin mul_a = p_r[31:0];             mul_b = cfg.stop_tolerances[15:0]; end
      MS_NU:   begin mul_a = nominc_r;              mul_b = cfg.stop_tolerances[31:16]; end
      MS_LL:   begin
        mul_a = {17'd0, cfg.stop_speed_limit};
        mul_b = {1'b0, cfg.stop_speed_limit};
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod = {16'd0, mul_a} * {32'd0, mul_b};

  always_ff @(posedge clk) begin
    p_r <= prod;
    if (cmd.load) begin
      walk_r   <= walk_request;
      cmd_r[0] <= cmd_vel_x;
      cmd_r[1] <= cmd_vel_y;
      cmd_r[2] <= cmd_vel_z;
      t_r      <= tick_time;
      tn_r     <= nominal_tick_time;
      sum_r    <= '0;
    end else begin
      case (cmd.cap_sel)
        CAP_ALIM0: alim_r[0] <= p_r[31:16];
        CAP_ALIM1: alim_r[1] <= p_r[31:16];
        CAP_ALIM2: alim_r[2] <= p_r[31:16];
        CAP_DLIM0: dlim_r[0] <= p_r[47:28];
        CAP_DLIM1: dlim_r[1] <= p_r[47:28];
        CAP_DLIM2: dlim_r[2] <= p_r[47:28];
        CAP_SQ:    sum_r     <= sum_r + {2'b00, p_r[29:0]};
        CAP_INC:   inc_r     <= p_r[31:16];
        CAP_NOM:   nominc_r  <= p_r[31:0];
        CAP_LB:    lb_r      <= p_r[47:24];
        CAP_UB:    ub_r      <= p_r[47:24];
        CAP_LIM2:  lim2_r    <= p_r[29:0];
        default: ;
      endcase
    end
  end

  // phase advance and stop window
  logic [31:0]           inc32;
  logic signed [PW-1:0]  newp;
  logic signed [PKW-1:0] nk, ok, lbk, ubk, halfk;
  logic                  n_ge0, n_le0, o_ge0, o_le0;
  logic                  crossing, slow, stop, start;
  logic [UW-1:0]         lim_u;

  assign inc32 = {16'd0, inc_r};
  assign newp  = phase_r + inc32[PW-1:0];
  assign nk    = $signed({{(PKW-PW){newp[PW-1]}}, newp});
  assign ok    = $signed({{(PKW-PW){phase_r[PW-1]}}, phase_r});
  assign lbk   = $signed({{(PKW-24){1'b0}}, lb_r});
  assign ubk   = $signed({{(PKW-24){1'b0}}, ub_r});
  assign halfk = $signed({{(PKW-PW){1'b0}}, 1'b1, {(PW-1){1'b0}}});
  assign n_ge0 = !newp[PW-1];
  assign n_le0 = newp[PW-1] || (newp == '0);
  assign o_ge0 = !phase_r[PW-1];
  assign o_le0 = phase_r[PW-1] || (phase_r == '0);
  assign crossing = (n_ge0 && o_le0 && ((nk <= ubk) || (ok >= -lbk))) ||
                    (n_le0 && o_ge0 && ((nk <= ubk - halfk) || (ok >= halfk - lbk)));

  assign lim_u = {{(UW-15){1'b0}}, cfg.stop_speed_limit};
  assign slow  = (mag[0] <= lim_u) && (mag[1] <= lim_u) && (mag[2] <= lim_u) &&
                 (sum_r <= {2'b00, lim2_r});

  assign stop  = walking_r && !walk_r && slow && crossing;
  assign start = !walking_r && walk_r;

  always_comb begin
    walking_nxt = walking_r;
    phase_nxt   = phase_r;
    left_nxt    = left_r;
    for (int i = 0; i < 3; i++) begin
      vel_nxt[i] = vel_r[i];
    end
    if (stop || start) begin
      walking_nxt = start;
      phase_nxt   = '0;
      left_nxt    = cfg.left_leg_leads;
      for (int i = 0; i < 3; i++) begin
        vel_nxt[i] = bias_sat[i];
      end
    end else if (walking_r) begin
      phase_nxt = newp;
      for (int i = 0; i < 3; i++) begin
        vel_nxt[i] = vel_new[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walking_r <= 1'b0;
      phase_r   <= '0;
      left_r    <= 1'b1;
      for (int i = 0; i < 3; i++) begin
        vel_r[i] <= '0;
      end
    end else if (cmd.update) begin
      walking_r <= walking_nxt;
      phase_r   <= phase_nxt;
      left_r    <= left_nxt;
      for (int i = 0; i < 3; i++) begin
        vel_r[i] <= vel_nxt[i];
      end
    end
  end

  assign stat.walking = walking_r;
  assign is_walking   = walking_r;
  assign vel_x        = vel_r[0];
  assign vel_y        = vel_r[1];
  assign vel_z        = vel_r[2];
  assign phase        = phase_r;
  assign leading_left = left_r;

`ifndef NO_ASSERTIONS
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.update |=> $stable(walking_r) && $stable(phase_r) && $stable(left_r))
    else $error("gait state moved outside an update");
  a_halted_phase_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !walking_r |-> phase_r == '0)
    else $error("phase nonzero while halted");
  a_start_clears_phase: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update && start |=> walking_r && phase_r == '0)
    else $error("start did not reload the gait state");
`endif

endmodule

// ----- design/gait_velocity_phase_generator.sv -----
// Top level: gait velocity slope limiter and phase generator.
`timescale 1ns / 1ps
// Usage
//   in_ch  : one word per control tick (walk request, velocity command, tick times).
//   out_ch : one word per input word, the gait state after that tick's update.
//   cfg_ch : register writes, always ready; write only while no word is in flight.
// Sequence
//   While walking a word goes from acceptance through the take cycle, 15 steps
//   that share one 32x16 multiplier for the limit, square and phase products,
//   and the update cycle, which waits for the output to free. The result is
//   valid the next cycle. While halted a word goes from the take cycle straight
//   to the update cycle. A new word is taken once the previous one has been
//   updated, not before.
// Reset
//   rst_n low clears the sequencer, drops out_ch.valid, halts the gait with zero
//   velocity and phase and loads the registers with their reset values.
// Stalls
//   The result word holds in the output state until taken; the next word may be
//   accepted and worked on meanwhile, but its update waits for the output to free.
module gait_velocity_phase_generator #(
  parameter int VEL_WIDTH   = gvp_pkg::VEL_WIDTH_DEF,
  parameter int PHASE_WIDTH = gvp_pkg::PHASE_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  gvp_in_if.sink    in_ch,
  gvp_out_if.source out_ch,
  gvp_cfg_if.sink   cfg_ch
);
  import gvp_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // configuration never stalls
  assign cfg_ch.ready = 1'b1;

  gvp_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid & cfg_ch.ready),
    .wr_index (cfg_ch.reg_index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  // sequencer owns both handshakes
  gvp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // the gait state registers drive the result word directly
  gvp_dp #(
    .VEL_WIDTH   (VEL_WIDTH),
    .PHASE_WIDTH (PHASE_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .walk_request      (in_ch.walk_request),
    .cmd_vel_x         (in_ch.cmd_vel_x),
    .cmd_vel_y         (in_ch.cmd_vel_y),
    .cmd_vel_z         (in_ch.cmd_vel_z),
    .tick_time         (in_ch.tick_time),
    .nominal_tick_time (in_ch.nominal_tick_time),
    .cfg               (cfg),
    .cmd               (cmd),
    .stat              (stat),
    .is_walking        (out_ch.is_walking),
    .vel_x             (out_ch.vel_x),
    .vel_y             (out_ch.vel_y),
    .vel_z             (out_ch.vel_z),
    .phase             (out_ch.phase),
    .leading_left      (out_ch.leading_left)
  );

endmodule

// ----- dv/gvp_gait_checker.sv -----
// Scoreboard for the gait block: mirrors the registers, predicts each result word, compares.
`timescale 1ns / 1ps
module gvp_gait_checker (
  input  logic        clk,
  input  logic        rst_n,
  gvp_in_if           tick_mon,
  gvp_out_if          gait_mon,
  gvp_cfg_if          reg_mon,
  output int unsigned fail_count,
  output int unsigned pending_words,
  output int unsigned checked_words
);
  import gvp_pkg::*;

  localparam int VEL_W = VEL_WIDTH_DEF;
  localparam int PH_W  = PHASE_WIDTH_DEF;

  typedef struct packed {
    logic                    walking;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic signed [VEL_W-1:0] vz;
    logic signed [PH_W-1:0]  phase;
    logic                    lead_left;
  } gait_word_t;

  gait_word_t expected_words [$];

  // register mirror and gait state
  cfg_t   regs;
  logic   walking;
  longint vel [3];
  longint phase_acc;
  logic   lead_left;

  initial begin
    fail_count    = 0;
    pending_words = 0;
    checked_words = 0;
  end

  function automatic longint axis_bias(int axis);
    logic signed [15:0] b;
    b = regs.velocity_bias[16*axis +: 16];
    return b;
  endfunction

  function automatic longint clamp_vel(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (VEL_W - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  // Reload velocity with the bias, clear the phase, take the leading leg afresh.
  function automatic void restart_gait(logic walk_on);
    int i;
    walking = walk_on;
    for (i = 0; i < 3; i++) vel[i] = clamp_vel(axis_bias(i));
    phase_acc = 0;
    lead_left = regs.left_leg_leads;
  endfunction

  function automatic gait_word_t advance_gait(input logic walk, input logic signed [15:0] cx,
                                              input logic signed [15:0] cy,
                                              input logic signed [15:0] cz,
                                              input logic [15:0] t, input logic [15:0] tn);
    longint cmd [3];
    longint unb [3];
    longint tgt, step, lo, hi, a_lim, d_lim, old_ph, new_ph, lb, ub, half;
    longint unsigned tt, tt_nom, nom, accel, mag, sq_sum, lim;
    logic signed [PH_W-1:0] ph_wrap;
    logic slow, crossing;
    gait_word_t w;
    int i, sel;
    cmd[0] = cx;
    cmd[1] = cy;
    cmd[2] = cz;
    tt = t;
    tt_nom = tn;
    if (walking) begin
      for (i = 0; i < 3; i++) begin
        unb[i] = vel[i] - axis_bias(i);
        tgt = axis_bias(i) + (walk ? cmd[i] : 0);
        // x splits forward/backward by sign; y and z use one limit each
        if (i == 0) sel = (unb[i] >= 0) ? 0 : 1;
        else sel = i + 1;
        accel = regs.accel_limits[16*sel +: 16];
        a_lim = (tt * accel) >> 16;
        d_lim = (tt * accel * regs.decel_ratio) >> 28;
        if (unb[i] >= 0) begin
          lo = -d_lim;
          hi = a_lim;
        end else begin
          lo = -a_lim;
          hi = d_lim;
        end
        step = tgt - vel[i];
        if (step < lo) step = lo;
        if (step > hi) step = hi;
        vel[i] = clamp_vel(vel[i] + step);
      end
      lim = regs.stop_speed_limit;
      slow = 1'b1;
      sq_sum = 0;
      for (i = 0; i < 3; i++) begin
        mag = (unb[i] < 0) ? -unb[i] : unb[i];
        if (mag > lim) slow = 1'b0;
        else sq_sum += mag * mag;
      end
      if (sq_sum > lim * lim) slow = 1'b0;
      old_ph = phase_acc;
      ph_wrap = PH_W'(old_ph + ((tt * regs.phase_rate) >> 16));
      new_ph = ph_wrap;
      phase_acc = new_ph;
      half = longint'(1) <<< (PH_W - 1);
      nom = tt_nom * regs.phase_rate;
      lb = (nom * regs.stop_tolerances[15:0]) >> 24;
      ub = (nom * regs.stop_tolerances[31:16]) >> 24;
      crossing = (new_ph >= 0 && old_ph <= 0 && (new_ph <= ub || old_ph >= -lb)) ||
                 (new_ph <= 0 && old_ph >= 0 && (new_ph <= ub - half || old_ph >= half - lb));
      if (!walk && slow && crossing) restart_gait(1'b0);
    end
    if (walk && !walking) restart_gait(1'b1);
    w.walking   = walking;
    w.vx        = VEL_W'(vel[0]);
    w.vy        = VEL_W'(vel[1]);
    w.vz        = VEL_W'(vel[2]);
    w.phase     = PH_W'(phase_acc);
    w.lead_left = lead_left;
    return w;
  endfunction

  task automatic check_field(input string field, input logic signed [63:0] want_v,
                             input logic signed [63:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    gait_word_t want;
    if (!rst_n) begin
      regs = CFG_RESET;
      walking = 1'b0;
      vel[0] = 0;
      vel[1] = 0;
      vel[2] = 0;
      phase_acc = 0;
      lead_left = 1'b1;
      expected_words.delete();
    end else begin
      // Retire the result first: it can never belong to a word taken at this edge.
      if (gait_mon.valid === 1'b1 && gait_mon.ready === 1'b1) begin
        if (expected_words.size() == 0) begin
          $display("%0t: result word with nothing expected", $time);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          check_field("is_walking", want.walking, gait_mon.is_walking);
          check_field("vel_x", want.vx, gait_mon.vel_x);
          check_field("vel_y", want.vy, gait_mon.vel_y);
          check_field("vel_z", want.vz, gait_mon.vel_z);
          check_field("phase", want.phase, gait_mon.phase);
          check_field("leading_left", want.lead_left, gait_mon.leading_left);
          checked_words++;
        end
      end
      if (reg_mon.valid === 1'b1 && reg_mon.ready === 1'b1) begin
        case (reg_mon.reg_index)
          REG_VELOCITY_BIAS:    regs.velocity_bias    = reg_mon.data[47:0];
          REG_ACCEL_LIMITS:     regs.accel_limits     = reg_mon.data;
          REG_DECEL_RATIO:      regs.decel_ratio      = reg_mon.data[15:0];
          REG_PHASE_RATE:       regs.phase_rate       = reg_mon.data[15:0];
          REG_STOP_TOLERANCES:  regs.stop_tolerances  = reg_mon.data[31:0];
          REG_STOP_SPEED_LIMIT: regs.stop_speed_limit = reg_mon.data[14:0];
          REG_LEFT_LEG_LEADS:   regs.left_leg_leads   = reg_mon.data[0];
          default: ;  // drop writes past the register list
        endcase
      end
      if (tick_mon.valid === 1'b1 && tick_mon.ready === 1'b1)
        expected_words.push_back(advance_gait(tick_mon.walk_request, tick_mon.cmd_vel_x,
                                              tick_mon.cmd_vel_y, tick_mon.cmd_vel_z,
                                              tick_mon.tick_time,
                                              tick_mon.nominal_tick_time));
    end
    pending_words = expected_words.size();
  end

endmodule

// ----- dv/gait_velocity_phase_generator_tb.sv -----
// Testbench top: drives tick words and register writes into the gait block and gives the verdict.
`timescale 1ns / 1ps
module gait_velocity_phase_generator_tb;
  import gvp_pkg::*;

  // Index one past the register list; the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int unsigned WORDS_PER_SETTING = 135;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned words_sent = 0;
  int unsigned settings_applied = 0;
  int unsigned fail_count, pending_words, checked_words;

  gvp_in_if  tick_ch ();
  gvp_out_if gait_ch ();
  gvp_cfg_if reg_ch ();

  gait_velocity_phase_generator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (tick_ch),
    .out_ch (gait_ch),
    .cfg_ch (reg_ch)
  );

  gvp_gait_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .tick_mon      (tick_ch),
    .gait_mon      (gait_ch),
    .reg_mon       (reg_ch),
    .fail_count    (fail_count),
    .pending_words (pending_words),
    .checked_words (checked_words)
  );

  // 4 ns period, low first.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: drop ready at random per the current stall rate, one decision per cycle.
  always @(negedge clk) begin
    gait_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Hard ceiling on the run; a normal run ends far earlier.
  initial begin
    #4_000_000;
    $display("Timed out at %0t with %0d result words outstanding", $time, pending_words);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Velocity command: mostly modest walking speeds, sometimes anything in range.
  function automatic logic [15:0] pick_cmd();
    if ($urandom_range(99) < 70) return 16'($urandom_range(0, 16'h3000)) - 16'h1800;
    return 16'($urandom);
  endfunction

  // Offer one tick word. Entered and left at a falling edge; valid stays high on
  // return so back-to-back words never lower and raise it in one step.
  task automatic send_tick(input logic walk, input logic [15:0] cx, input logic [15:0] cy,
                           input logic [15:0] cz, input logic [15:0] t,
                           input logic [15:0] tn);
    while ($urandom_range(99) < send_idle_pct) begin
      tick_ch.valid <= 1'b0;
      @(negedge clk);
    end
    tick_ch.valid             <= 1'b1;
    tick_ch.walk_request      <= walk;
    tick_ch.cmd_vel_x         <= cx;
    tick_ch.cmd_vel_y         <= cy;
    tick_ch.cmd_vel_z         <= cz;
    tick_ch.tick_time         <= t;
    tick_ch.nominal_tick_time <= tn;
    do @(posedge clk); while (tick_ch.ready !== 1'b1);
    @(negedge clk);
    words_sent++;
  endtask

  // Write one register; the caller drops valid after the last write of a group.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
    reg_ch.valid     <= 1'b1;
    reg_ch.reg_index <= idx;
    reg_ch.data      <= value;
    do @(posedge clk); while (reg_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [63:0] bias, input logic [63:0] accel,
                               input logic [63:0] decel, input logic [63:0] rate,
                               input logic [63:0] tol, input logic [63:0] spd,
                               input logic [63:0] lead);
    write_reg(REG_SPARE, {$urandom, $urandom});
    write_reg(REG_VELOCITY_BIAS, bias);
    write_reg(REG_ACCEL_LIMITS, accel);
    write_reg(REG_DECEL_RATIO, decel);
    write_reg(REG_PHASE_RATE, rate);
    write_reg(REG_STOP_TOLERANCES, tol);
    write_reg(REG_STOP_SPEED_LIMIT, spd);
    write_reg(REG_LEFT_LEG_LEADS, lead);
    reg_ch.valid <= 1'b0;
    settings_applied++;
  endtask

  // Hold off new words until every result already owed has come back.
  task automatic drain();
    tick_ch.valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned mode, k, i, target, base, nwalk;
    logic [15:0] cx, cy, cz;
    logic [63:0] junk, bias, accel, decel, rate, tol, spd, lead;

    // Known values on every input from time zero.
    tick_ch.valid             = 1'b0;
    tick_ch.walk_request      = 1'b0;
    tick_ch.cmd_vel_x         = '0;
    tick_ch.cmd_vel_y         = '0;
    tick_ch.cmd_vel_z         = '0;
    tick_ch.tick_time         = '0;
    tick_ch.nominal_tick_time = '0;
    gait_ch.ready             = 1'b0;
    reg_ch.valid              = 1'b0;
    reg_ch.reg_index          = REG_VELOCITY_BIAS;
    reg_ch.data               = '0;

    send_idle_pct = 37;
    stall_pct     = 80;

    // Hold reset, then release it on a falling edge.
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, extreme registers: x bias at the top end and y bias at the bottom end,
    // every limit at full scale, widest tolerances, leading leg flipped to right.
    apply_setting(64'h0000_1234_8000_7FFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF, 64'hFFFF,
                  64'hFFFF_FFFF, 64'h7FFF, 64'h0);
    send_tick(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);  // halted, no request
    send_tick(1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF);  // start from halt
    send_tick(1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF);  // saturate high
    send_tick(1'b1, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF);  // full swing low
    send_tick(1'b1, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000);  // zero nominal
    send_tick(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);  // zero tick, no motion
    send_tick(1'b0, 16'h1234, 16'h5678, 16'h9ABC, 16'hFFFF, 16'hFFFF);  // release request
    send_tick(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0001);
    send_tick(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000);
    send_tick(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain();

    // Directed, frozen velocity and zero tolerances: each tick moves the phase a
    // quarter turn, so stops land exactly on zero and on the most negative code.
    apply_setting(64'h0, 64'h0, 64'h1000, 64'h8000, 64'h0, 64'h0, 64'h1);
    send_tick(1'b1, pick_cmd(), pick_cmd(), pick_cmd(), 16'h8000, 16'h8000);  // start
    send_tick(1'b0, pick_cmd(), pick_cmd(), pick_cmd(), 16'h8000, 16'h8000);  // leave zero: stop
    send_tick(1'b1, pick_cmd(), pick_cmd(), pick_cmd(), 16'h8000, 16'h8000);  // start again
    send_tick(1'b1, pick_cmd(), pick_cmd(), pick_cmd(), 16'h8000, 16'h8000);  // quarter turn
    send_tick(1'b0, pick_cmd(), pick_cmd(), pick_cmd(), 16'h8000, 16'h8000);  // land on -pi
    send_tick(1'b1, pick_cmd(), pick_cmd(), pick_cmd(), 16'h8000, 16'h8000);
    send_tick(1'b1, pick_cmd(), pick_cmd(), pick_cmd(), 16'h8000, 16'h8000);
    send_tick(1'b1, pick_cmd(), pick_cmd(), pick_cmd(), 16'h8000, 16'h8000);
    send_tick(1'b1, pick_cmd(), pick_cmd(), pick_cmd(), 16'h8000, 16'h8000);  // three quarters
    send_tick(1'b0, pick_cmd(), pick_cmd(), pick_cmd(), 16'h8000, 16'h8000);  // wrap onto zero
    send_tick(1'b0, pick_cmd(), pick_cmd(), pick_cmd(), 16'h8000, 16'h8000);  // halted again

    // Random part: three idle mixes, three register settings each.
    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 37;
          stall_pct     = 80;
        end
        1: begin
          send_idle_pct = 80;
          stall_pct     = 37;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
      endcase
      for (k = 0; k < 3; k++) begin
        drain();
        if (mode == 0 && k == 0) begin
          // all registers at zero: no slope, no phase motion, no tolerance
          apply_setting(64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0);
        end else if (mode == 1 && k == 0) begin
          // all register bits set
          apply_setting('1, '1, '1, '1, '1, '1, '1);
        end else begin
          // Plausible walking setup with junk above each register's width.
          junk = {$urandom, $urandom};
          bias = junk;
          for (i = 0; i < 3; i++)
            bias[16*i +: 16] = ($urandom_range(99) < 70) ?
                               16'($urandom_range(0, 16'h1000)) - 16'h0800 : 16'($urandom);
          for (i = 0; i < 4; i++)
            accel[16*i +: 16] = ($urandom_range(99) < 50) ?
                                16'($urandom_range(0, 16'h2000)) : 16'($urandom);
          decel = {junk[63:16], 16'($urandom_range(0, 16'h3000))};
          rate  = {junk[63:16], 16'($urandom_range(16'h1000, 16'hFFFF))};
          tol   = {junk[63:32], 16'($urandom_range(0, 16'h0600)),
                   16'($urandom_range(0, 16'h0600))};
          spd   = {junk[63:15], 15'($urandom_range(0, 15'h2000))};
          lead  = {junk[63:1], 1'($urandom)};
          apply_setting(bias, accel, decel, rate, tol, spd, lead);
        end

        target = words_sent + WORDS_PER_SETTING;
        while (words_sent < target) begin
          if ($urandom_range(99) < 80) begin
            // Well-formed stride: walk with a steady command that changes now and
            // then, then release and let the gait look for a stop crossing.
            base  = $urandom_range(1000, 16000);
            cx    = pick_cmd();
            cy    = pick_cmd();
            cz    = pick_cmd();
            nwalk = $urandom_range(1, 24);
            repeat (nwalk) begin
              if ($urandom_range(99) < 15) begin
                cx = pick_cmd();
                cy = pick_cmd();
                cz = pick_cmd();
              end
              send_tick(1'b1, cx, cy, cz, 16'(base + $urandom_range(0, 400) - 200), 16'(base));
            end
            repeat ($urandom_range(1, 30))
              send_tick(1'b0, pick_cmd(), pick_cmd(), pick_cmd(),
                        16'(base + $urandom_range(0, 400) - 200), 16'(base));
          end else begin
            // Noise: every field anywhere in its range.
            repeat ($urandom_range(1, 8))
              send_tick(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom));
          end
        end
      end
    end

    // Let the last results come home, then give the block some slack.
    drain();
    repeat (40) @(negedge clk);

    $display("Covered %0d tick words under %0d register settings, %0d result words compared.",
             words_sent, settings_applied, checked_words);
    $display("Idle mixes: sender-heavy, receiver-heavy, then back-to-back.");
    if (fail_count == 0 && pending_words == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
